@@ src/rar_pkg.sv @@
// rar_pkg: shared types and constants for the rational arithmetic reducer.
// Holds the sequencer state type, opcode and status codes, datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package rar_pkg;

   localparam int DATA_W = 64;
   localparam int MUL_W  = 33;
   localparam int CNT_W  = $clog2(DATA_W);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PREP,
      S_MUL_N,
      S_MUL_D,
      S_GCD_TEST,
      S_GCD_WAIT,
      S_LCM_GO,
      S_LCM_WAIT,
      S_QA_GO,
      S_QA_WAIT,
      S_QB_GO,
      S_QB_WAIT,
      S_MUL_TA,
      S_MUL_TT,
      S_SUM,
      S_CHECK,
      S_RED_CHK,
      S_RNUM_GO,
      S_RNUM_WAIT,
      S_RDEN_GO,
      S_RDEN_WAIT,
      S_OUT
   } state_type;

endpackage

@@ src/rar_div.sv @@
// rar_div: 64-bit signed truncating divider, one quotient bit per cycle.
// Gives quotient and remainder with C sign rules. Depends on rar_pkg.
`timescale 1ns / 1ps

module rar_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rar_pkg::word_type dividend,
   input  rar_pkg::word_type divisor,
   output logic              done,
   output rar_pkg::word_type quotient,
   output rar_pkg::word_type remainder
);

   logic                         busy_ff;
   logic                         done_ff;
   logic [rar_pkg::CNT_W-1:0]    cnt_ff;
   logic [rar_pkg::DATA_W-1:0]   acc_ff;
   logic [rar_pkg::DATA_W-1:0]   quo_ff;
   logic [rar_pkg::DATA_W-1:0]   dsr_ff;
   logic                         negq_ff;
   logic                         negr_ff;
   logic [rar_pkg::DATA_W:0]     trial;
   logic [rar_pkg::DATA_W-1:0]   acc_in;
   logic                         qbit;

   always_comb begin
      trial = {acc_ff, quo_ff[rar_pkg::DATA_W-1]} - {1'b0, dsr_ff};
      qbit  = ~trial[rar_pkg::DATA_W];
      if (qbit) begin
         acc_in = trial[rar_pkg::DATA_W-1:0];
      end else begin
         acc_in = {acc_ff[rar_pkg::DATA_W-2:0], quo_ff[rar_pkg::DATA_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (&cnt_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         quo_ff  <= dividend[rar_pkg::DATA_W-1] ? -dividend : dividend;
         dsr_ff  <= divisor[rar_pkg::DATA_W-1] ? -divisor : divisor;
         negq_ff <= dividend[rar_pkg::DATA_W-1] ^ divisor[rar_pkg::DATA_W-1];
         negr_ff <= dividend[rar_pkg::DATA_W-1];
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         quo_ff <= {quo_ff[rar_pkg::DATA_W-2:0], qbit};
      end
   end

   assign done      = done_ff;
   assign quotient  = negq_ff ? -quo_ff : quo_ff;
   assign remainder = negr_ff ? -acc_ff : acc_ff;

endmodule

@@ src/rational_arith_reduce_top.sv @@
// rational_arith_reduce_top: adds, subtracts, multiplies or divides two fractions
// and reduces the result by Euclid's gcd. Uses rar_pkg and rar_div.
//
// channel | dir | transfer when          | payload
// req     | in  | req_valid & !req_stall | opcode, a_num, a_den, b_num, b_den
// rsp     | out | rsp_valid & !rsp_stall | res_num, res_den, status
//
// One item at a time; req_stall is high from acceptance until the result transfers.
// Every 64-bit division runs on the single shared divider. A zero denominator skips
// the gcd loops and the reduction; the two gcd loops plus lcm and reduction need up
// to about 140 divisions on the worst item.
// Synchronous active-high reset returns the sequencer to idle.
// A stalled result holds until taken.
`timescale 1ns / 1ps

module rational_arith_reduce_top #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_a_num,
   input  logic [31:0] req_a_den,
   input  logic [31:0] req_b_num,
   input  logic [31:0] req_b_den,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_res_num,
   output logic [63:0] rsp_res_den,
   output logic [1:0]  rsp_status
);

   localparam int W = rar_pkg::DATA_W;

   rar_pkg::state_type state_ff, state_in;

   logic [1:0]        op_ff;
   rar_pkg::word_type an_ff, ad_ff, bn_ff, bd_ff;
   rar_pkg::word_type num_ff, den_ff, gn_ff, gd_ff, qa_ff, qb_ff;
   logic              phase_ff;
   logic [1:0]        status_ff;

   logic              div_start, div_done;
   rar_pkg::word_type div_dvd, div_dsr, div_q, div_r;

   logic signed [rar_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*rar_pkg::MUL_W-1:0] mul_p;
   rar_pkg::word_type                  mul_res;
   rar_pkg::word_type                  sum;
   logic                               sum_ovf;
   rar_pkg::word_type                  min_word;

   function automatic rar_pkg::word_type sext(input logic [31:0] x);
      sext = {{(W-OPERAND_WIDTH){x[OPERAND_WIDTH-1]}}, x[OPERAND_WIDTH-1:0]};
   endfunction

   rar_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign min_word = {1'b1, {(W-1){1'b0}}};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rar_pkg::S_IDLE: begin
            if (req_valid) state_in = rar_pkg::S_PREP;
         end
         rar_pkg::S_PREP: begin
            if (op_ff[1]) begin
               state_in = rar_pkg::S_MUL_N;
            end else if (ad_ff == bd_ff || ad_ff == '0 || bd_ff == '0) begin
               state_in = rar_pkg::S_CHECK;
            end else begin
               state_in = rar_pkg::S_MUL_N;
            end
         end
         rar_pkg::S_MUL_N:
            state_in = op_ff[1] ? rar_pkg::S_MUL_D : rar_pkg::S_GCD_TEST;
         rar_pkg::S_MUL_D:    state_in = rar_pkg::S_CHECK;
         rar_pkg::S_GCD_TEST: begin
            if (gd_ff != '0) begin
               state_in = rar_pkg::S_GCD_WAIT;
            end else begin
               state_in = phase_ff ? rar_pkg::S_RED_CHK : rar_pkg::S_LCM_GO;
            end
         end
         rar_pkg::S_GCD_WAIT: if (div_done) state_in = rar_pkg::S_GCD_TEST;
         rar_pkg::S_LCM_GO:   state_in = rar_pkg::S_LCM_WAIT;
         rar_pkg::S_LCM_WAIT: if (div_done) state_in = rar_pkg::S_QA_GO;
         rar_pkg::S_QA_GO:    state_in = rar_pkg::S_QA_WAIT;
         rar_pkg::S_QA_WAIT:  if (div_done) state_in = rar_pkg::S_QB_GO;
         rar_pkg::S_QB_GO:    state_in = rar_pkg::S_QB_WAIT;
         rar_pkg::S_QB_WAIT:  if (div_done) state_in = rar_pkg::S_MUL_TA;
         rar_pkg::S_MUL_TA:   state_in = rar_pkg::S_MUL_TT;
         rar_pkg::S_MUL_TT:   state_in = rar_pkg::S_SUM;
         rar_pkg::S_SUM:      state_in = rar_pkg::S_CHECK;
         rar_pkg::S_CHECK: begin
            if (status_ff == rar_pkg::STAT_OK && den_ff != '0) begin
               state_in = rar_pkg::S_GCD_TEST;
            end else begin
               state_in = rar_pkg::S_OUT;
            end
         end
         rar_pkg::S_RED_CHK: begin
            if (gn_ff == '1 && (num_ff == min_word || den_ff == min_word)) begin
               state_in = rar_pkg::S_OUT;
            end else begin
               state_in = rar_pkg::S_RNUM_GO;
            end
         end
         rar_pkg::S_RNUM_GO:   state_in = rar_pkg::S_RNUM_WAIT;
         rar_pkg::S_RNUM_WAIT: if (div_done) state_in = rar_pkg::S_RDEN_GO;
         rar_pkg::S_RDEN_GO:   state_in = rar_pkg::S_RDEN_WAIT;
         rar_pkg::S_RDEN_WAIT: if (div_done) state_in = rar_pkg::S_OUT;
         rar_pkg::S_OUT:       if (!rsp_stall) state_in = rar_pkg::S_IDLE;
         default:              state_in = rar_pkg::S_IDLE;
      endcase
   end

   // outputs: divider and multiplier operand selection
   always_comb begin
      div_start = 1'b0;
      div_dvd   = num_ff;
      div_dsr   = gn_ff;
      mul_a     = ad_ff[rar_pkg::MUL_W-1:0];
      mul_b     = bd_ff[rar_pkg::MUL_W-1:0];
      unique case (state_ff)
         rar_pkg::S_GCD_TEST: begin
            div_start = (gd_ff != '0);
            div_dvd   = gn_ff;
            div_dsr   = gd_ff;
         end
         rar_pkg::S_LCM_GO:  div_start = 1'b1;
         rar_pkg::S_QA_GO: begin
            div_start = 1'b1;
            div_dvd   = den_ff;
            div_dsr   = ad_ff;
         end
         rar_pkg::S_QB_GO: begin
            div_start = 1'b1;
            div_dvd   = den_ff;
            div_dsr   = bd_ff;
         end
         rar_pkg::S_RNUM_GO: div_start = 1'b1;
         rar_pkg::S_RDEN_GO: begin
            div_start = 1'b1;
            div_dvd   = den_ff;
         end
         rar_pkg::S_MUL_N: begin
            if (op_ff[1]) begin
               mul_a = an_ff[rar_pkg::MUL_W-1:0];
               mul_b = op_ff[0] ? bd_ff[rar_pkg::MUL_W-1:0] : bn_ff[rar_pkg::MUL_W-1:0];
            end
         end
         rar_pkg::S_MUL_D: begin
            mul_b = op_ff[0] ? bn_ff[rar_pkg::MUL_W-1:0] : bd_ff[rar_pkg::MUL_W-1:0];
         end
         rar_pkg::S_MUL_TA: begin
            mul_a = qa_ff[rar_pkg::MUL_W-1:0];
            mul_b = an_ff[rar_pkg::MUL_W-1:0];
         end
         rar_pkg::S_MUL_TT: begin
            mul_a = qb_ff[rar_pkg::MUL_W-1:0];
            mul_b = bn_ff[rar_pkg::MUL_W-1:0];
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign mul_res = mul_p[W-1:0];
   assign sum     = qa_ff + qb_ff;
   assign sum_ovf = (qa_ff[W-1] == qb_ff[W-1]) && (sum[W-1] != qa_ff[W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rar_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rar_pkg::S_IDLE: begin
            op_ff     <= req_opcode;
            an_ff     <= sext(req_a_num);
            ad_ff     <= sext(req_a_den);
            bn_ff     <= sext(req_b_num);
            bd_ff     <= sext(req_b_den);
            status_ff <= rar_pkg::STAT_OK;
            phase_ff  <= 1'b0;
         end
         rar_pkg::S_PREP: begin
            if (!op_ff[1]) begin
               if (op_ff == rar_pkg::OP_SUB) bn_ff <= -bn_ff;
               num_ff <= an_ff + ((op_ff == rar_pkg::OP_SUB) ? -bn_ff : bn_ff);
               den_ff <= (ad_ff == bd_ff) ? ad_ff : '0;
            end
         end
         rar_pkg::S_MUL_N: begin
            num_ff <= mul_res;
            gn_ff  <= ad_ff;
            gd_ff  <= bd_ff;
         end
         rar_pkg::S_MUL_D: den_ff <= mul_res;
         rar_pkg::S_GCD_WAIT: begin
            if (div_done) begin
               gn_ff <= gd_ff;
               gd_ff <= div_r;
            end
         end
         rar_pkg::S_LCM_WAIT: if (div_done) den_ff <= div_q;
         rar_pkg::S_QA_WAIT:  if (div_done) qa_ff <= div_q;
         rar_pkg::S_QB_WAIT:  if (div_done) qb_ff <= div_q;
         rar_pkg::S_MUL_TA:   qa_ff <= mul_res;
         rar_pkg::S_MUL_TT:   qb_ff <= mul_res;
         rar_pkg::S_SUM: begin
            num_ff <= sum;
            if (sum_ovf) status_ff <= rar_pkg::STAT_OVERFLOW;
         end
         rar_pkg::S_CHECK: begin
            if (status_ff == rar_pkg::STAT_OK && den_ff == '0) begin
               status_ff <= rar_pkg::STAT_ZERO_DEN;
            end
            gn_ff    <= num_ff;
            gd_ff    <= den_ff;
            phase_ff <= 1'b1;
         end
         rar_pkg::S_RED_CHK: begin
            if (gn_ff == '1 && (num_ff == min_word || den_ff == min_word)) begin
               status_ff <= rar_pkg::STAT_OVERFLOW;
            end
         end
         rar_pkg::S_RNUM_WAIT: if (div_done) num_ff <= div_q;
         rar_pkg::S_RDEN_WAIT: if (div_done) den_ff <= div_q;
         default: begin
            phase_ff <= phase_ff;
         end
      endcase
   end

   assign req_stall   = (state_ff != rar_pkg::S_IDLE);
   assign rsp_valid   = (state_ff == rar_pkg::S_OUT);
   assign rsp_res_num = (status_ff == rar_pkg::STAT_OK) ? num_ff : '0;
   assign rsp_res_den = (status_ff == rar_pkg::STAT_OK) ? den_ff : '0;
   assign rsp_status  = status_ff;

endmodule

@@ verif/testbench.sv @@
// testbench: drives rational_arith_reduce_top with fraction pairs and checks every result
// against a typed expected value or an in-bench calculator with truncating-remainder gcd
// reduction. Depends on rar_pkg and the rational_arith_reduce_top RTL.
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] an, ad, bn, bd;
   } frac_req_type;

   typedef struct {
      logic [63:0] num, den;
      logic [1:0]  st;
   } frac_rsp_type;

   localparam int IDLE_LIMIT = 60000;
   localparam int RANDOM_ITEMS = 1430;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = rar_pkg::OP_ADD;
   logic [31:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_res_num, rsp_res_den;
   logic [1:0]  rsp_status;

   frac_rsp_type pending_q[$];
   int           mismatches = 0;
   int           results_seen = 0;
   int           status_seen[3] = '{0, 0, 0};
   int           idle_cycles = 0;
   bit           burst = 1'b0;

   rational_arith_reduce_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den), .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint trunc_gcd(longint n, longint d);
      longint r;
      while (d != 0) begin
         r = (d == -1) ? 64'sd0 : n % d;
         n = d;
         d = r;
      end
      return n;
   endfunction

   function automatic frac_rsp_type reduce_fraction(frac_req_type q);
      frac_rsp_type res;
      longint an, ad, bn, bd, tb, num, den, lcm, ta, tt, g;
      logic [1:0] st;
      an = longint'(signed'(q.an));
      ad = longint'(signed'(q.ad));
      bn = longint'(signed'(q.bn));
      bd = longint'(signed'(q.bd));
      num = 0;
      den = 0;
      st = rar_pkg::STAT_OK;
      if (q.op == rar_pkg::OP_ADD || q.op == rar_pkg::OP_SUB) begin
         tb = (q.op == rar_pkg::OP_ADD) ? bn : -bn;
         if (ad == bd) begin
            den = ad;
            num = an + tb;
         end else if (ad == 0 || bd == 0) begin
            den = 0;
         end else begin
            lcm = (ad * bd) / trunc_gcd(ad, bd);
            ta = (lcm / ad) * an;
            tt = (lcm / bd) * tb;
            den = lcm;
            num = ta + tt;
            if ((ta < 0) == (tt < 0) && (num < 0) != (ta < 0))
               st = rar_pkg::STAT_OVERFLOW;
         end
      end else if (q.op == rar_pkg::OP_MUL) begin
         num = an * bn;
         den = ad * bd;
      end else begin
         num = an * bd;
         den = ad * bn;
      end
      if (st == rar_pkg::STAT_OK && den == 0)
         st = rar_pkg::STAT_ZERO_DEN;
      if (st == rar_pkg::STAT_OK) begin
         g = trunc_gcd(num, den);
         if (g == -1 && (num == 64'sh8000000000000000 || den == 64'sh8000000000000000)) begin
            st = rar_pkg::STAT_OVERFLOW;
         end else begin
            num = num / g;
            den = den / g;
         end
      end
      if (st != rar_pkg::STAT_OK) begin
         num = 0;
         den = 0;
      end
      res.num = num;
      res.den = den;
      res.st = st;
      return res;
   endfunction

   function automatic int pick_gap();
      int p;
      if (burst)
         return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   function automatic logic [31:0] pick_value(bit nonzero);
      logic [31:0] v;
      int p;
      p = $urandom_range(0, 99);
      if (p < 60)
         v = 32'(int'($urandom_range(0, 60)) - 30);
      else if (p < 75)
         v = 32'(int'($urandom_range(0, 4000)) - 2000);
      else if (p < 82)
         v = $urandom_range(0, 3) == 0 ? 32'h80000000 : ($urandom_range(0, 1) ? 32'h7fffffff
                                                                              : 32'hffffffff);
      else
         v = $urandom;
      if (nonzero && v == 0 && $urandom_range(0, 9) != 0)
         v = 32'd1;
      return v;
   endfunction

   task automatic send_fraction(frac_req_type q, bit typed, frac_rsp_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= q.op;
      req_a_num  <= q.an;
      req_a_den  <= q.ad;
      req_b_num  <= q.bn;
      req_b_den  <= q.bd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_q.push_back(typed ? want : reduce_fraction(q));
   endtask

   task automatic send_row(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd, bit typed,
                           logic [63:0] en, logic [63:0] ed, logic [1:0] es);
      frac_req_type q;
      frac_rsp_type w;
      q = '{op, an, ad, bn, bd};
      w = '{en, ed, es};
      send_fraction(q, typed, w);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            frac_rsp_type w;
            results_seen++;
            if (rsp_status < 3) status_seen[rsp_status]++;
            if (pending_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result num=%0d den=%0d status=%0d",
                           $signed(rsp_res_num), $signed(rsp_res_den), rsp_status);
            end else begin
               w = pending_q.pop_front();
               if (w.num !== rsp_res_num || w.den !== rsp_res_den || w.st !== rsp_status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                              results_seen, $signed(w.num), $signed(w.den), w.st,
                              $signed(rsp_res_num), $signed(rsp_res_den), rsp_status);
               end
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stall_gen
      int n;
      forever begin
         @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("rational_arith_reduce_top verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      frac_req_type q;
      int p;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_row(rar_pkg::OP_ADD, 1, 2, 1, 2, 1, 1, 1, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_SUB, 1, 2, 1, 2, 1, 0, 1, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_MUL, 2, 3, 3, 4, 1, 1, 2, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_DIV, 1, 2, 1, 4, 1, 2, 1, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_MUL, 1, 1, 1, -1, 1, -1, 1, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_MUL, 5, 0, 3, 7, 1, 0, 0, rar_pkg::STAT_ZERO_DEN);
      send_row(rar_pkg::OP_DIV, 5, 3, 0, 7, 1, 0, 0, rar_pkg::STAT_ZERO_DEN);
      send_row(rar_pkg::OP_ADD, 1, 0, 1, 5, 1, 0, 0, rar_pkg::STAT_ZERO_DEN);
      send_row(rar_pkg::OP_SUB, 1, 0, 1, 0, 1, 0, 0, rar_pkg::STAT_ZERO_DEN);
      send_row(rar_pkg::OP_ADD, 1, 3, 1, 6, 0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_SUB, -1, -3, 5, 4, 0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
               0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_SUB, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7ffffffe,
               0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_SUB, 32'h80000000, 32'h80000001, 32'h7fffffff, 32'h7fffffff,
               0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_MUL, 32'h80000000, 1, 32'h80000000, 1,
               0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_MUL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
               0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_DIV, 32'h80000000, 32'hffffffff, 32'h80000000, 32'hffffffff,
               0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_DIV, 32'hffffffff, 32'h7fffffff, 32'hffffffff, 32'h80000000,
               0, 0, 0, rar_pkg::STAT_OK);
      send_row(rar_pkg::OP_ADD, 0, 32'hffffffff, 0, 32'hffffffff,
               0, 0, 0, rar_pkg::STAT_OK);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0)
            burst = ($urandom_range(0, 3) == 0);
         q.op = 2'($urandom_range(0, 3));
         q.an = pick_value(1'b0);
         q.ad = pick_value(1'b1);
         q.bn = pick_value(q.op == rar_pkg::OP_DIV);
         q.bd = pick_value(1'b1);
         p = $urandom_range(0, 9);
         if (p < 2)
            q.bd = q.ad;
         else if (p == 2)
            q.ad = $urandom;
         send_fraction(q, 1'b0, '{64'd0, 64'd0, rar_pkg::STAT_OK});
      end
      req_valid <= 1'b0;

      while (pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("fractions checked: %0d results, %0d ok, %0d zero-denominator, %0d overflow",
               results_seen, status_seen[0], status_seen[1], status_seen[2]);
      if (mismatches == 0 && pending_q.size() == 0)
         $display("rational_arith_reduce_top verification clean");
      else
         $display("rational_arith_reduce_top verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
src/rar_pkg.sv
src/rar_div.sv
src/rational_arith_reduce_top.sv
verif/testbench.sv
